/* rtl/core/rhp_pkg.sv */
// shared constants, types and codes for the rtp header parser
`timescale 1ns / 1ps

package rhp_pkg;

    localparam int          MAX_SOURCES    = 15;
    localparam logic [15:0] MAX_PACKET_LEN = 16'd65535;
    localparam int          SRC_IDX_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int          QUEUE_DEPTH    = 2;
    localparam int          QUEUE_PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [15:0] FIXED_HDR_LEN  = 16'd12;
    localparam int          PAD_BIT        = 5;
    localparam int          EXT_BIT        = 4;

    typedef enum logic [1:0] {
        KIND_CSRC    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_SHORT   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CALC,
        B_SIZE,
        B_CSRC,
        B_SUM,
        B_SHORT
    } t_back_state;

    typedef struct packed {
        logic                        short_pkt;
        logic [7:0]                  first_byte;
        logic [7:0]                  second_byte;
        logic [15:0]                 seq;
        logic [31:0]                 stamp;
        logic [31:0]                 ssrc;
        logic [MAX_SOURCES-1:0][31:0] csrc;
        logic [15:0]                 ext_word;
        logic [7:0]                  last_byte;
        logic [15:0]                 len;
    } t_pkt;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  version;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
        logic [31:0] identifier;
        logic [3:0]  source_count;
        logic [18:0] extension_size;
        logic [18:0] payload_offset;
        logic [15:0] payload_size;
        logic [7:0]  padding_size;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/core/rhp_front.sv */
// byte capture front end: header fields, csrc words, extension length word
`timescale 1ns / 1ps

module rhp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_packet,
    input  rhp_pkg::t_q_status i_q_status,
    output logic              o_stall,
    output logic              o_push,
    output rhp_pkg::t_pkt     o_pkt
);
    import rhp_pkg::*;

    logic [15:0]                  r_byte_count, n_byte_count;
    logic [7:0]                   r_first_byte, n_first_byte;
    logic [7:0]                   r_second_byte, n_second_byte;
    logic [15:0]                  r_seq, n_seq;
    logic [31:0]                  r_stamp, n_stamp;
    logic [31:0]                  r_ssrc, n_ssrc;
    logic [MAX_SOURCES-1:0][31:0] r_csrc, n_csrc;
    logic [15:0]                  r_ext_word, n_ext_word;

    logic        w_accept;
    logic        w_in_range;
    logic [3:0]  w_cc;
    logic [15:0] w_ext_pos;
    logic [15:0] w_csrc_pos;
    logic [13:0] w_csrc_idx;
    logic [15:0] w_len;

    always_comb begin
        w_accept   = i_valid && !i_q_status.full;
        w_in_range = r_byte_count < MAX_PACKET_LEN;
        w_cc       = r_first_byte[3:0];
        w_ext_pos  = 16'd14 + {10'd0, w_cc, 2'b00};
        w_csrc_pos = r_byte_count - FIXED_HDR_LEN;
        w_csrc_idx = w_csrc_pos[15:2];
        w_len      = w_in_range ? (r_byte_count + 16'd1) : r_byte_count;

        n_byte_count  = r_byte_count;
        n_first_byte  = r_first_byte;
        n_second_byte = r_second_byte;
        n_seq         = r_seq;
        n_stamp       = r_stamp;
        n_ssrc        = r_ssrc;
        n_csrc        = r_csrc;
        n_ext_word    = r_ext_word;

        if (w_accept) begin
            // new packet starts with an empty csrc list and extension word
            if (r_byte_count == 16'd0) begin
                n_csrc     = '0;
                n_ext_word = '0;
            end
            if (w_in_range) begin
                n_byte_count = r_byte_count + 16'd1;
                if (r_byte_count == 16'd0) begin
                    n_first_byte = i_data_byte;
                end else if (r_byte_count == 16'd1) begin
                    n_second_byte = i_data_byte;
                end else if (r_byte_count < 16'd4) begin
                    n_seq = {r_seq[7:0], i_data_byte};
                end else if (r_byte_count < 16'd8) begin
                    n_stamp = {r_stamp[23:0], i_data_byte};
                end else if (r_byte_count < FIXED_HDR_LEN) begin
                    n_ssrc = {r_ssrc[23:0], i_data_byte};
                end else if (w_csrc_idx < 14'(MAX_SOURCES)) begin
                    n_csrc[w_csrc_idx[SRC_IDX_W-1:0]] =
                        {r_csrc[w_csrc_idx[SRC_IDX_W-1:0]][23:0], i_data_byte};
                end
                if (r_byte_count == w_ext_pos || r_byte_count == (w_ext_pos + 16'd1)) begin
                    n_ext_word = {r_ext_word[7:0], i_data_byte};
                end
            end
            if (i_end_of_packet) begin
                n_byte_count = '0;
            end
        end

        o_stall = i_q_status.full;
        o_push  = w_accept && i_end_of_packet;

        o_pkt.short_pkt   = w_len < FIXED_HDR_LEN;
        o_pkt.first_byte  = n_first_byte;
        o_pkt.second_byte = n_second_byte;
        o_pkt.seq         = n_seq;
        o_pkt.stamp       = n_stamp;
        o_pkt.ssrc        = n_ssrc;
        o_pkt.csrc        = n_csrc;
        o_pkt.ext_word    = n_ext_word;
        o_pkt.last_byte   = i_data_byte;
        o_pkt.len         = w_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
        end else begin
            r_byte_count <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_byte  <= n_first_byte;
        r_second_byte <= n_second_byte;
        r_seq         <= n_seq;
        r_stamp       <= n_stamp;
        r_ssrc        <= n_ssrc;
        r_csrc        <= n_csrc;
        r_ext_word    <= n_ext_word;
    end

endmodule

/* rtl/core/rhp_queue.sv */
// packet descriptor queue between capture front end and result back end
`timescale 1ns / 1ps

module rhp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rhp_pkg::t_pkt      i_pkt,
    input  logic               i_pop,
    output rhp_pkg::t_pkt      o_pkt,
    output rhp_pkg::t_q_status o_status
);
    import rhp_pkg::*;

    t_pkt                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                       r_wr_ptr + QUEUE_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                       r_rd_ptr + QUEUE_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_PTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QUEUE_PTR_W+1)'(1);
        end
        o_pkt          = r_mem[r_rd_ptr];
        o_status.full  = r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
        o_status.empty = r_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

endmodule

/* rtl/core/rhp_back.sv */
// result back end: size arithmetic, csrc word sequencing, output register
`timescale 1ns / 1ps

module rhp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rhp_pkg::t_q_status i_q_status,
    input  rhp_pkg::t_pkt      i_pkt,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output rhp_pkg::t_result   o_result
);
    import rhp_pkg::*;

    t_back_state r_state, n_state;
    t_pkt        r_pkt, n_pkt;
    logic [18:0] r_ext, n_ext;
    logic [18:0] r_off, n_off;
    logic [18:0] r_hdr_pad, n_hdr_pad;
    logic [7:0]  r_pad, n_pad;
    logic        r_csrc_ok, n_csrc_ok;
    logic [15:0] r_psize, n_psize;
    logic [3:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        w_free;
    logic [3:0]  w_cc;
    logic [18:0] w_hdr;
    logic [18:0] w_len;
    logic [18:0] w_used;

    always_comb begin
        w_free = !r_out_valid || !i_stall;
        w_cc   = r_pkt.first_byte[3:0];
        w_hdr  = 19'd12 + {13'd0, w_cc, 2'b00};
        w_len  = {3'd0, r_pkt.len};
        w_used = r_hdr_pad + r_ext;

        n_state     = r_state;
        n_pkt       = r_pkt;
        n_ext       = r_ext;
        n_off       = r_off;
        n_hdr_pad   = r_hdr_pad;
        n_pad       = r_pad;
        n_csrc_ok   = r_csrc_ok;
        n_psize     = r_psize;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_pop       = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_pkt   = i_pkt;
                    n_state = B_CALC;
                end
            end
            B_CALC: begin
                if (r_pkt.short_pkt) begin
                    n_state = B_SHORT;
                end else begin
                    n_csrc_ok = w_len >= w_hdr;
                    n_pad     = r_pkt.first_byte[PAD_BIT] ? r_pkt.last_byte : 8'd0;
                    n_hdr_pad = w_hdr + {11'd0, n_pad};
                    n_ext     = (r_pkt.first_byte[EXT_BIT] && w_len >= (w_hdr + 19'd4)) ?
                                ({1'b0, r_pkt.ext_word, 2'b00} + 19'd4) : 19'd0;
                    n_state   = B_SIZE;
                end
            end
            B_SIZE: begin
                n_off   = w_hdr + r_ext;
                n_psize = (w_used < w_len) ? (r_pkt.len - w_used[15:0]) : 16'd0;
                n_idx   = '0;
                n_state = (w_cc != 4'd0) ? B_CSRC : B_SUM;
            end
            B_CSRC: begin
                if (w_free) begin
                    n_out              = '0;
                    n_out.kind         = KIND_CSRC;
                    n_out.identifier   = (r_csrc_ok && {1'b0, r_idx} < 5'(MAX_SOURCES)) ?
                                         r_pkt.csrc[r_idx[SRC_IDX_W-1:0]] : 32'd0;
                    n_out.source_count = r_idx;
                    n_out_valid        = 1'b1;
                    n_idx              = r_idx + 4'd1;
                    if (r_idx == (w_cc - 4'd1)) begin
                        n_state = B_SUM;
                    end
                end
            end
            B_SUM: begin
                if (w_free) begin
                    n_out.kind            = KIND_SUMMARY;
                    n_out.version         = r_pkt.first_byte[7:6];
                    n_out.marker          = r_pkt.second_byte[7];
                    n_out.payload_type    = r_pkt.second_byte[6:0];
                    n_out.sequence_number = r_pkt.seq;
                    n_out.timestamp       = r_pkt.stamp;
                    n_out.identifier      = r_pkt.ssrc;
                    n_out.source_count    = w_cc;
                    n_out.extension_size  = r_ext;
                    n_out.payload_offset  = r_off;
                    n_out.payload_size    = r_psize;
                    n_out.padding_size    = r_pad;
                    n_out_valid           = 1'b1;
                    n_state               = B_IDLE;
                end
            end
            B_SHORT: begin
                if (w_free) begin
                    n_out       = '0;
                    n_out.kind  = KIND_SHORT;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        o_valid  = r_out_valid;
        o_result = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt     <= n_pkt;
        r_ext     <= n_ext;
        r_off     <= n_off;
        r_hdr_pad <= n_hdr_pad;
        r_pad     <= n_pad;
        r_csrc_ok <= n_csrc_ok;
        r_psize   <= n_psize;
        r_idx     <= n_idx;
        r_out     <= n_out;
    end

endmodule

/* rtl/core/rtp_header_parser.sv */
// top level of the rtp fixed-header parser
`timescale 1ns / 1ps

// Accepts one packet byte per cycle while o_stall is low, with i_end_of_packet on
// the last byte. The front end captures header, csrc words and the extension
// length word as bytes stream in; on the last byte it hands a packet descriptor
// to a two-entry queue and goes straight on with the next packet. The back end
// sets up each descriptor in turn (load, extension and csrc checks, offset and
// payload size), then, while the downstream side does not stall, emits one result
// per cycle: CC csrc words and the summary, or a single short-packet result.
// Input is stalled only while both queue entries are occupied, so the front end
// takes in new packets while the back end is still busy with earlier ones.
// Results wait in an output register while the downstream side stalls.
module rtp_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_version,
    output logic        o_marker,
    output logic [6:0]  o_payload_type,
    output logic [15:0] o_sequence_number,
    output logic [31:0] o_timestamp,
    output logic [31:0] o_identifier,
    output logic [3:0]  o_source_count,
    output logic [18:0] o_extension_size,
    output logic [18:0] o_payload_offset,
    output logic [15:0] o_payload_size,
    output logic [7:0]  o_padding_size
);
    import rhp_pkg::*;

    t_q_status w_q_status;
    t_pkt      w_push_pkt;
    t_pkt      w_pop_pkt;
    logic      w_push;
    logic      w_pop;
    t_result   w_result;

    rhp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_q_status      (w_q_status),
        .o_stall         (o_stall),
        .o_push          (w_push),
        .o_pkt           (w_push_pkt)
    );

    rhp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pkt    (w_push_pkt),
        .i_pop    (w_pop),
        .o_pkt    (w_pop_pkt),
        .o_status (w_q_status)
    );

    rhp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_pkt      (w_pop_pkt),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (w_result)
    );

    assign o_kind            = w_result.kind;
    assign o_version         = w_result.version;
    assign o_marker          = w_result.marker;
    assign o_payload_type    = w_result.payload_type;
    assign o_sequence_number = w_result.sequence_number;
    assign o_timestamp       = w_result.timestamp;
    assign o_identifier      = w_result.identifier;
    assign o_source_count    = w_result.source_count;
    assign o_extension_size  = w_result.extension_size;
    assign o_payload_offset  = w_result.payload_offset;
    assign o_payload_size    = w_result.payload_size;
    assign o_padding_size    = w_result.padding_size;

endmodule

/* rtl/core/rhp_checker.sv */
// port-level checks for the rtp header parser, bound to the top level
`timescale 1ns / 1ps

module rhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic [1:0]  o_kind,
    input logic [31:0] o_timestamp,
    input logic [31:0] o_identifier,
    input logic [3:0]  o_source_count,
    input logic [18:0] o_extension_size,
    input logic [18:0] o_payload_offset,
    input logic [15:0] o_payload_size
);
    import rhp_pkg::*;

    // stalled transaction keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_identifier) && $stable(o_kind))
        else $error("stalled result changed");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_SUMMARY |->
        o_payload_offset == 19'd12 + {13'd0, o_source_count, 2'b00} + o_extension_size)
        else $error("payload offset inconsistent with csrc count and extension");

    a_csrc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_CSRC |->
        o_timestamp == 32'd0 && o_extension_size == 19'd0 && o_payload_size == 16'd0)
        else $error("csrc result carries summary fields");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_SHORT |->
        o_identifier == 32'd0 && o_payload_offset == 19'd0 && o_source_count == 4'd0)
        else $error("short packet result not cleared");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (.*);
